// ===== rtl/core/drul_pkg.sv =====
// drul_pkg: shared types and codes for the damage rectangle list.
// No dependencies.
`timescale 1ns / 1ps
package drul_pkg;
    localparam int CW = 16;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_DUMP  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_RSVD  = 2'd3;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_RECT = 1'b1;

    typedef struct packed {
        logic [CW-1:0] x0;
        logic [CW-1:0] y0;
        logic [CW-1:0] x1;
        logic [CW-1:0] y1;
    } box_t;

    typedef struct packed {
        logic [1:0]    op;
        logic [CW-1:0] in_min_x;
        logic [CW-1:0] in_min_y;
        logic [CW-1:0] in_max_x;
        logic [CW-1:0] in_max_y;
    } cmd_word_t;

    typedef struct packed {
        logic          kind;
        logic [CW-1:0] out_min_x;
        logic [CW-1:0] out_min_y;
        logic [CW-1:0] out_max_x;
        logic [CW-1:0] out_max_y;
        logic [6:0]    list_count;
        logic          overflow;
        logic          entry_valid;
        logic          last;
    } res_word_t;

    // Outcome of comparing the current piece against one stored rectangle.
    typedef struct packed {
        logic covered;   // piece inside stored: drop piece
        logic remove;    // remove stored (inside piece or merged)
        logic cur_wr;    // piece replaced by cur_new
        logic st_wr;     // stored replaced by st_new
        logic push;      // queue rest
    } act_t;
endpackage

// ===== rtl/core/drul_cmp.sv =====
// drul_cmp: compare/clip/split unit, one stored rectangle against the piece.
// Depends on drul_pkg.
`timescale 1ns / 1ps
module drul_cmp (
    input  drul_pkg::box_t cur,
    input  drul_pkg::box_t ir,
    output drul_pkg::act_t act,
    output drul_pkg::box_t cur_new,
    output drul_pkg::box_t st_new,
    output drul_pkg::box_t rest
);
    import drul_pkg::*;

    box_t c;
    logic tch, ovl;

    always_comb
    begin
        act     = '0;
        cur_new = cur;
        st_new  = ir;
        rest    = cur;
        tch = ir.x0 <= cur.x1 && cur.x0 <= ir.x1 && ir.y0 <= cur.y1 && cur.y0 <= ir.y1;
        ovl = ir.x0 < cur.x1 && cur.x0 < ir.x1 && ir.y0 < cur.y1 && cur.y0 < ir.y1;
        c.x0 = (cur.x0 > ir.x0) ? cur.x0 : ir.x0;
        c.y0 = (cur.y0 > ir.y0) ? cur.y0 : ir.y0;
        c.x1 = (cur.x1 < ir.x1) ? cur.x1 : ir.x1;
        c.y1 = (cur.y1 < ir.y1) ? cur.y1 : ir.y1;
        if (tch)
        begin
            if (ir.x0 <= cur.x0 && cur.x1 <= ir.x1 && ir.y0 <= cur.y0 && cur.y1 <= ir.y1)
                act.covered = 1'b1;
            else if (cur.x0 <= ir.x0 && ir.x1 <= cur.x1 && cur.y0 <= ir.y0
                     && ir.y1 <= cur.y1)
                act.remove = 1'b1;
            else if ((ir.y0 == cur.y0 && ir.y1 == cur.y1)
                     || (ir.x0 == cur.x0 && ir.x1 == cur.x1))
            begin
                act.remove = 1'b1;
                act.cur_wr = 1'b1;
                if (ir.x0 < cur.x0) cur_new.x0 = ir.x0;
                if (ir.y0 < cur.y0) cur_new.y0 = ir.y0;
                if (ir.x1 > cur.x1) cur_new.x1 = ir.x1;
                if (ir.y1 > cur.y1) cur_new.y1 = ir.y1;
            end
            else if (ovl)
            begin
                act.cur_wr = 1'b1;
                // trim piece
                if (cur.y0 == c.y0 && cur.y1 == c.y1 && cur.x0 == c.x0)
                    cur_new.x0 = c.x1;
                else if (cur.y0 == c.y0 && cur.y1 == c.y1 && cur.x1 == c.x1)
                    cur_new.x1 = c.x0;
                else if (cur.x0 == c.x0 && cur.x1 == c.x1 && cur.y0 == c.y0)
                    cur_new.y0 = c.y1;
                else if (cur.x0 == c.x0 && cur.x1 == c.x1 && cur.y1 == c.y1)
                    cur_new.y1 = c.y0;
                // trim stored
                else if (ir.y0 == c.y0 && ir.y1 == c.y1 && ir.x0 == c.x0)
                begin
                    act.cur_wr = 1'b0; act.st_wr = 1'b1; st_new.x0 = c.x1;
                end
                else if (ir.y0 == c.y0 && ir.y1 == c.y1 && ir.x1 == c.x1)
                begin
                    act.cur_wr = 1'b0; act.st_wr = 1'b1; st_new.x1 = c.x0;
                end
                else if (ir.x0 == c.x0 && ir.x1 == c.x1 && ir.y0 == c.y0)
                begin
                    act.cur_wr = 1'b0; act.st_wr = 1'b1; st_new.y0 = c.y1;
                end
                else if (ir.x0 == c.x0 && ir.x1 == c.x1 && ir.y1 == c.y1)
                begin
                    act.cur_wr = 1'b0; act.st_wr = 1'b1; st_new.y1 = c.y0;
                end
                // band
                else if (cur.x0 == c.x0 && cur.x1 == c.x1 && cur.y0 < c.y0 && c.y1 < cur.y1)
                begin
                    act.push = 1'b1; cur_new.y1 = c.y0; rest.y0 = c.y1;
                end
                else if (cur.y0 == c.y0 && cur.y1 == c.y1 && cur.x0 < c.x0 && c.x1 < cur.x1)
                begin
                    act.push = 1'b1; cur_new.x1 = c.x0; rest.x0 = c.x1;
                end
                // corner
                else if (c.x0 == cur.x0 && c.y0 == cur.y0)
                begin
                    act.push = 1'b1;
                    rest    = '{x0: c.x1, y0: c.y0, x1: cur.x1, y1: cur.y1};
                    cur_new = '{x0: c.x0, y0: c.y1, x1: c.x1, y1: cur.y1};
                end
                else if (c.x0 == cur.x0 && c.y1 == cur.y1)
                begin
                    act.push = 1'b1;
                    rest    = '{x0: c.x1, y0: cur.y0, x1: cur.x1, y1: cur.y1};
                    cur_new = '{x0: cur.x0, y0: cur.y0, x1: c.x1, y1: c.y0};
                end
                else if (c.x1 == cur.x1 && c.y1 == cur.y1)
                begin
                    act.push = 1'b1;
                    rest    = '{x0: c.x0, y0: cur.y0, x1: c.x1, y1: c.y0};
                    cur_new = '{x0: cur.x0, y0: cur.y0, x1: c.x0, y1: c.y1};
                end
                else if (c.x1 == cur.x1 && c.y0 == cur.y0)
                begin
                    act.push = 1'b1;
                    rest    = '{x0: c.x0, y0: c.y1, x1: cur.x1, y1: cur.y1};
                    cur_new = '{x0: cur.x0, y0: cur.y0, x1: c.x0, y1: cur.y1};
                end
                else
                    act.cur_wr = 1'b0;
            end
        end
    end
endmodule

// ===== rtl/core/dirty_rectangle_union_list_top.sv =====
// dirty_rectangle_union_list_top: damage rectangle list, sequencer and stores.
// Depends on drul_pkg and drul_cmp.
`timescale 1ns / 1ps
// Command word in on start while busy is low; every result word appears for
// one cycle with res_valid high and cannot be held off. Per queued piece, an
// add latches the piece, then reads each stored rectangle and passes it
// through the shared compare unit; a store removal also moves the last
// entry into the freed slot, and a surviving piece is appended at S_END.
// Dump reads, then sends, each entry; clear and empty adds go to the ack.
// The store and work queue are single-port memories.
module dirty_rectangle_union_list_top #(
    parameter int MAX_RECTS  = 64,
    parameter int WORK_DEPTH = 16,
    parameter int COORD_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  drul_pkg::cmd_word_t  cmd,
    output logic                 busy,
    output logic                 res_valid,
    output drul_pkg::res_word_t  res
);
    import drul_pkg::*;

    localparam int RI = $clog2(MAX_RECTS);
    localparam int RC = $clog2(MAX_RECTS + 1);
    localparam int WI = $clog2(WORK_DEPTH);
    localparam int WC = $clog2(WORK_DEPTH + 1);
    localparam logic [CW-1:0] CMASK = CW'((32'd1 << COORD_BITS) - 32'd1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PIECE = 4'd1;  // read piece j
    localparam logic [3:0] S_PLOAD = 4'd2;  // latch piece
    localparam logic [3:0] S_RD    = 4'd3;  // read store[i]
    localparam logic [3:0] S_CMP   = 4'd4;  // compare
    localparam logic [3:0] S_MVRD  = 4'd5;  // read last entry
    localparam logic [3:0] S_MVWR  = 4'd6;  // write into slot i
    localparam logic [3:0] S_END   = 4'd7;  // piece scan done
    localparam logic [3:0] S_ACK   = 4'd8;
    localparam logic [3:0] S_DRD   = 4'd9;
    localparam logic [3:0] S_DOUT  = 4'd10;

    box_t store_mem [MAX_RECTS];
    box_t work_mem  [WORK_DEPTH];
    box_t st_rd_reg, wq_rd_reg;

    logic [3:0]    state_reg;
    logic [RC-1:0] count_reg;
    logic [WC-1:0] wcount_reg;
    logic [WC-1:0] j_reg;
    logic [RC-1:0] i_reg;
    logic          ovf_reg;
    box_t          bbox_reg, cur_reg;

    // memory request (single port each)
    logic          st_we, wq_we;
    logic [RI-1:0] st_addr;
    logic [WI-1:0] wq_addr;
    box_t          st_wd, wq_wd;

    act_t act;
    box_t cur_new, st_new, rest;
    box_t in_box;

    drul_cmp u_cmp (
        .cur(cur_reg), .ir(st_rd_reg), .act(act),
        .cur_new(cur_new), .st_new(st_new), .rest(rest)
    );

    assign busy = (state_reg != S_IDLE);
    assign in_box = '{x0: cmd.in_min_x & CMASK, y0: cmd.in_min_y & CMASK,
                      x1: cmd.in_max_x & CMASK, y1: cmd.in_max_y & CMASK};

    always_ff @(posedge clk)
    begin
        if (st_we) store_mem[st_addr] <= st_wd;
        st_rd_reg <= store_mem[st_addr];
        if (wq_we) work_mem[wq_addr] <= wq_wd;
        wq_rd_reg <= work_mem[wq_addr];
    end

    logic [RC-1:0] last_idx;
    assign last_idx = count_reg - RC'(1);

    always_comb
    begin
        st_we   = 1'b0;
        st_addr = i_reg[RI-1:0];
        st_wd   = st_new;
        wq_we   = 1'b0;
        wq_addr = j_reg[WI-1:0];
        wq_wd   = rest;
        case (state_reg)
            S_IDLE:
            begin
                // first piece into queue slot 0
                wq_we   = start && !busy && cmd.op == OP_ADD;
                wq_addr = '0;
                wq_wd   = in_box;
                st_addr = '0;
            end
            S_CMP:
            begin
                if (act.st_wr) st_we = 1'b1;
                if (act.push && wcount_reg < WC'(WORK_DEPTH))
                begin
                    wq_we   = 1'b1;
                    wq_addr = wcount_reg[WI-1:0];
                end
                if (act.remove) st_addr = last_idx[RI-1:0];
            end
            // count already lowered: the old last entry sits at the new count
            S_MVRD: st_addr = count_reg[RI-1:0];
            S_MVWR:
            begin
                st_we = 1'b1;
                st_wd = st_rd_reg;
            end
            S_END:
            begin
                st_addr = count_reg[RI-1:0];
                st_wd   = cur_reg;
                st_we   = count_reg < RC'(MAX_RECTS);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            wcount_reg <= '0;
            j_reg      <= '0;
            i_reg      <= '0;
            ovf_reg    <= 1'b0;
            bbox_reg   <= '0;
            cur_reg    <= '0;
            res_valid  <= 1'b0;
            res        <= '0;
        end
        else
        begin
            res_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                    if (start)
                    begin
                        if (cmd.op == OP_DUMP)
                            state_reg <= S_DRD;
                        else if (cmd.op == OP_CLEAR)
                        begin
                            count_reg  <= '0;
                            wcount_reg <= '0;
                            ovf_reg    <= 1'b0;
                            state_reg  <= S_ACK;
                        end
                        else if (cmd.op == OP_ADD && in_box.x0 < in_box.x1
                                 && in_box.y0 < in_box.y1)
                        begin
                            if (in_box.x0 < bbox_reg.x0) bbox_reg.x0 <= in_box.x0;
                            if (in_box.y0 < bbox_reg.y0) bbox_reg.y0 <= in_box.y0;
                            if (in_box.x1 > bbox_reg.x1) bbox_reg.x1 <= in_box.x1;
                            if (in_box.y1 > bbox_reg.y1) bbox_reg.y1 <= in_box.y1;
                            wcount_reg <= WC'(1);
                            state_reg  <= S_PIECE;
                        end
                        else
                            state_reg <= S_ACK;
                    end
                end
                S_PIECE:
                begin
                    i_reg <= '0;
                    state_reg <= (j_reg < wcount_reg) ? S_PLOAD : S_ACK;
                end
                S_PLOAD:
                begin
                    cur_reg   <= wq_rd_reg;
                    state_reg <= S_RD;
                end
                S_RD:
                    state_reg <= (i_reg < count_reg) ? S_CMP : S_END;
                S_CMP:
                begin
                    if (act.covered)
                    begin
                        j_reg     <= j_reg + WC'(1);
                        state_reg <= S_PIECE;
                    end
                    else
                    begin
                        if (act.cur_wr) cur_reg <= cur_new;
                        if (act.push)
                        begin
                            if (wcount_reg < WC'(WORK_DEPTH))
                                wcount_reg <= wcount_reg + WC'(1);
                            else
                                ovf_reg <= 1'b1;
                        end
                        if (act.remove)
                        begin
                            count_reg <= last_idx;
                            state_reg <= S_MVRD;
                        end
                        else
                        begin
                            i_reg     <= i_reg + RC'(1);
                            state_reg <= S_RD;
                        end
                    end
                end
                S_MVRD: state_reg <= S_MVWR;  // last entry read under new count
                S_MVWR: state_reg <= S_RD;    // same i rescanned
                S_END:
                begin
                    if (count_reg < RC'(MAX_RECTS))
                        count_reg <= count_reg + RC'(1);
                    else
                        ovf_reg <= 1'b1;
                    j_reg     <= j_reg + WC'(1);
                    state_reg <= S_PIECE;
                end
                S_ACK:
                begin
                    res_valid       <= 1'b1;
                    res.kind        <= KIND_ACK;
                    res.out_min_x   <= bbox_reg.x0;
                    res.out_min_y   <= bbox_reg.y0;
                    res.out_max_x   <= bbox_reg.x1;
                    res.out_max_y   <= bbox_reg.y1;
                    res.list_count  <= 7'(count_reg);
                    res.overflow    <= ovf_reg;
                    res.entry_valid <= 1'b0;
                    res.last        <= 1'b1;
                    state_reg       <= S_IDLE;
                end
                S_DRD: state_reg <= S_DOUT;
                S_DOUT:
                begin
                    res_valid       <= 1'b1;
                    res.kind        <= KIND_RECT;
                    res.list_count  <= 7'(count_reg);
                    res.overflow    <= ovf_reg;
                    if (count_reg == '0)
                    begin
                        res.out_min_x   <= '0;
                        res.out_min_y   <= '0;
                        res.out_max_x   <= '0;
                        res.out_max_y   <= '0;
                        res.entry_valid <= 1'b0;
                        res.last        <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                    else
                    begin
                        res.out_min_x   <= st_rd_reg.x0;
                        res.out_min_y   <= st_rd_reg.y0;
                        res.out_max_x   <= st_rd_reg.x1;
                        res.out_max_y   <= st_rd_reg.y1;
                        res.entry_valid <= 1'b1;
                        res.last        <= (i_reg == last_idx);
                        i_reg           <= i_reg + RC'(1);
                        state_reg       <= (i_reg == last_idx) ? S_IDLE : S_DRD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
